FILE: sv/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg
// Shared constants and the divide-by-255 helper for the layer compositor.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int unsigned CHANNELS   = 3;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned PIXEL_W    = CHANNELS * CHAN_W;
    localparam int unsigned OVERLAY_W  = 32;
    localparam int unsigned ALPHA_LSB  = 24;
    localparam int unsigned PROD_W     = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'hFF;

    // floor(x / 255) for x up to 255*255, by reciprocal with correction
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
        return s[PROD_W-1:CHAN_W];
    endfunction

endpackage

FILE: sv/lac_blend_stage.sv
// ----------------------------------------------------------------------------
// lac_blend_stage
// Blends one overlay pixel over the running accumulator, all three channels,
// in two register stages: products, then scaled sum.
// ----------------------------------------------------------------------------
module lac_blend_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [lac_pkg::PIXEL_W-1:0]        i_acc,
    input  logic [lac_pkg::OVERLAY_W-1:0]      i_overlay,
    output logic                               o_valid,
    output logic [lac_pkg::PIXEL_W-1:0]        o_acc
);

    logic [lac_pkg::PROD_W-1:0] r_prod_c [lac_pkg::CHANNELS];
    logic [lac_pkg::PROD_W-1:0] r_prod_b [lac_pkg::CHANNELS];
    logic [lac_pkg::PROD_W-1:0] n_prod_c [lac_pkg::CHANNELS];
    logic [lac_pkg::PROD_W-1:0] n_prod_b [lac_pkg::CHANNELS];
    logic [lac_pkg::PIXEL_W-1:0] r_acc;
    logic [lac_pkg::PIXEL_W-1:0] n_acc;
    logic                        r_valid_p;
    logic                        r_valid_s;
    logic [lac_pkg::CHAN_W-1:0]  alpha;
    logic [lac_pkg::CHAN_W-1:0]  inv_alpha;

    assign alpha     = i_overlay[lac_pkg::ALPHA_LSB +: lac_pkg::CHAN_W];
    assign inv_alpha = lac_pkg::FULL_SCALE - alpha;

    // overlay and background products per channel
    always_comb begin
        for (int ch = 0; ch < lac_pkg::CHANNELS; ch++) begin
            n_prod_c[ch] = {8'd0, i_overlay[ch*lac_pkg::CHAN_W +: lac_pkg::CHAN_W]}
                         * {8'd0, alpha};
            n_prod_b[ch] = {8'd0, i_acc[ch*lac_pkg::CHAN_W +: lac_pkg::CHAN_W]}
                         * {8'd0, inv_alpha};
        end
    end

    // two truncated quotients summed; the sum stays within a byte
    always_comb begin
        logic [lac_pkg::CHAN_W:0] sum;
        sum   = '0;
        n_acc = '0;
        for (int ch = 0; ch < lac_pkg::CHANNELS; ch++) begin
            sum = {1'b0, lac_pkg::div255(r_prod_c[ch])}
                + {1'b0, lac_pkg::div255(r_prod_b[ch])};
            n_acc[ch*lac_pkg::CHAN_W +: lac_pkg::CHAN_W] = sum[lac_pkg::CHAN_W-1:0];
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_prod_c <= n_prod_c;
        r_prod_b <= n_prod_b;
        r_acc    <= n_acc;
    end

    // valid bits follow the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_s <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid_s <= r_valid_p;
        end
    end

    assign o_valid = r_valid_s;
    assign o_acc   = r_acc;

endmodule

FILE: sv/layer_alpha_compositor.sv
// ----------------------------------------------------------------------------
// layer_alpha_compositor
// Two register stages per overlay, from start to o_done through all three overlays.
// Throughput: one word per cycle; busy is always low, every stage of each
// overlay layer's multiply and scaled sum takes a new word in every cycle.
// Reset clears the valid bits only; results are never held off.
// ----------------------------------------------------------------------------
module layer_alpha_compositor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lac_pkg::PIXEL_W-1:0]    i_base_rgb,
    input  logic [lac_pkg::OVERLAY_W-1:0]  i_overlay_low,
    input  logic [lac_pkg::OVERLAY_W-1:0]  i_overlay_mid,
    input  logic [lac_pkg::OVERLAY_W-1:0]  i_overlay_top,
    output logic                           o_done,
    output logic [lac_pkg::PIXEL_W-1:0]    o_blended_rgb
);

    logic [lac_pkg::OVERLAY_W-1:0] r_mid_d1;
    logic [lac_pkg::OVERLAY_W-1:0] r_mid_d2;
    logic [lac_pkg::OVERLAY_W-1:0] r_top_d1;
    logic [lac_pkg::OVERLAY_W-1:0] r_top_d2;
    logic [lac_pkg::OVERLAY_W-1:0] r_top_d3;
    logic [lac_pkg::OVERLAY_W-1:0] r_top_d4;
    logic                          valid_low;
    logic                          valid_mid;
    logic [lac_pkg::PIXEL_W-1:0]   acc_low;
    logic [lac_pkg::PIXEL_W-1:0]   acc_mid;

    assign busy = 1'b0;

    // later overlays wait until their layer's stage comes round
    always_ff @(posedge i_clk) begin
        r_mid_d1 <= i_overlay_mid;
        r_mid_d2 <= r_mid_d1;
        r_top_d1 <= i_overlay_top;
        r_top_d2 <= r_top_d1;
        r_top_d3 <= r_top_d2;
        r_top_d4 <= r_top_d3;
    end

    // lowest overlay over the background
    lac_blend_stage u_blend_low (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_acc     (i_base_rgb),
        .i_overlay (i_overlay_low),
        .o_valid   (valid_low),
        .o_acc     (acc_low)
    );

    // middle overlay
    lac_blend_stage u_blend_mid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (valid_low),
        .i_acc     (acc_low),
        .i_overlay (r_mid_d2),
        .o_valid   (valid_mid),
        .o_acc     (acc_mid)
    );

    // top overlay, drives the result ports
    lac_blend_stage u_blend_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (valid_mid),
        .i_acc     (acc_mid),
        .i_overlay (r_top_d4),
        .o_valid   (o_done),
        .o_acc     (o_blended_rgb)
    );

endmodule
